>>> rtl/tvg_pkg.sv
// Shared constants, tables and types of the turtle vector generator.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tvg_pkg;

  // CORDIC and fixed-point set-up
  localparam int CORDIC_ITERATIONS = 16;
  localparam int FRACTION_BITS     = 16;
  localparam int GUARD_BITS        = 8;

  // command characters
  localparam logic [7:0] SYM_DRAW  = 8'd70;
  localparam logic [7:0] SYM_LEFT  = 8'd43;
  localparam logic [7:0] SYM_RIGHT = 8'd45;

  // inverse CORDIC gain, 0.6072529350 in Q32
  localparam logic [31:0] INV_GAIN_Q32 = 32'd2608131496;

  // field widths
  localparam int SYMBOL_W = 8;
  localparam int STEP_W   = 31;
  localparam int ANGLE_W  = 16;
  localparam int COORD_W  = 16;
  localparam int PEN_W    = 32;

  // datapath widths
  localparam int PROD_W  = STEP_W + 32;
  localparam int X_W     = PROD_W - (32 - GUARD_BITS) + 3;
  localparam int Z_W     = 34;
  localparam int ADD_W   = X_W - GUARD_BITS + 1;
  localparam int SAT_W   = 41;
  localparam int ITER_W  = $clog2(CORDIC_ITERATIONS);

  // atan(2^-i), 2^32 per full turn
  localparam int ATAN_DEPTH = 24;
  localparam int ATAN_IDX_W = 5;
  localparam logic [31:0] ATAN_TAB [ATAN_DEPTH] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;
  localparam logic [CFG_IDX_W-1:0] REG_STEP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TURN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_X = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic take;       // input item accepted this cycle
    logic mul;        // form step times inverse gain
    logic load;       // seed CORDIC registers
    logic iter;       // one CORDIC micro-rotation
    logic add;        // round rotated vector and add to pen
    logic emit_move;  // load pen-up result into output register
    logic emit_draw;  // load line result into output register
  } tvg_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_draw;    // offered item is 'F'
    logic in_restart; // offered item carries restart
    logic pend_draw;  // accepted item was 'F'
    logic out_free;   // output register can take a result
    logic iter_done;  // last CORDIC iteration in progress
  } tvg_stat_t;

endpackage

`default_nettype wire

>>> rtl/tvg_ctrl.sv
// Sequencing state machine of the turtle vector generator.
// Depends on tvg_pkg; drives tvg_datapath through tvg_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module tvg_ctrl
  import tvg_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  tvg_stat_t stat,
  output tvg_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MOVE = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_LOAD = 3'd3;
  localparam logic [2:0] S_ITER = 3'd4;
  localparam logic [2:0] S_ADD  = 3'd5;
  localparam logic [2:0] S_DRAW = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          if (stat.in_restart) begin
            state_next = S_MOVE;
          end else if (stat.in_draw) begin
            state_next = S_MUL;
          end
        end
      end
      S_MOVE: begin
        if (stat.out_free) begin
          cmd.emit_move = 1'b1;
          state_next    = stat.pend_draw ? S_MUL : S_IDLE;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd.load   = 1'b1;
        state_next = S_ITER;
      end
      S_ITER: begin
        cmd.iter = 1'b1;
        if (stat.iter_done) begin
          state_next = S_ADD;
        end
      end
      S_ADD: begin
        cmd.add    = 1'b1;
        state_next = S_DRAW;
      end
      S_DRAW: begin
        if (stat.out_free) begin
          cmd.emit_draw = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/tvg_datapath.sv
// Datapath of the turtle vector generator: configuration, pen and heading,
// gain multiplier, iterative CORDIC, rounding and the output register.
// Depends on tvg_pkg; commanded by tvg_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module tvg_datapath
  import tvg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  tvg_cmd_t              cmd,
  output tvg_stat_t             stat,
  input  logic [SYMBOL_W-1:0]   symbol,
  input  logic                  restart,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COORD_W-1:0]    out_x,
  output logic [COORD_W-1:0]    out_y,
  output logic                  out_down,
  output logic                  out_last
);

  localparam logic signed [SAT_W-1:0] PEN_MAX = SAT_W'(2147483647);
  localparam logic signed [SAT_W-1:0] PEN_MIN = -PEN_MAX - SAT_W'(1);

  // configuration
  logic [STEP_W-1:0]         step_length;
  logic [ANGLE_W-1:0]        turn_angle;
  logic signed [COORD_W-1:0] start_x;
  logic signed [COORD_W-1:0] start_y;

  // turtle state
  logic signed [PEN_W-1:0] pen_x;
  logic signed [PEN_W-1:0] pen_y;
  logic [ANGLE_W-1:0]      heading;
  logic [ANGLE_W-1:0]      heading_next;
  logic                    is_draw;

  // CORDIC working registers
  logic [PROD_W-1:0]     prod;
  logic signed [X_W-1:0] x;
  logic signed [X_W-1:0] y;
  logic signed [Z_W-1:0] z;
  logic [ITER_W-1:0]     iter;

  logic                  back_half;
  logic [ANGLE_W-1:0]    angle_rot;
  logic signed [X_W-1:0] x_seed;
  logic signed [Z_W-1:0] z_seed;
  logic signed [X_W-1:0] x_shift;
  logic signed [X_W-1:0] y_shift;
  logic signed [Z_W-1:0] atan_step;
  logic signed [X_W-1:0] x_guard;
  logic signed [X_W-1:0] y_guard;
  logic signed [ADD_W-1:0] x_sum;
  logic signed [ADD_W-1:0] y_sum;
  logic signed [SAT_W-1:0] start_x_fix;
  logic signed [SAT_W-1:0] start_y_fix;

  // saturate to the signed pen range
  function automatic logic signed [PEN_W-1:0] sat_pen(input logic signed [SAT_W-1:0] v);
    logic signed [PEN_W-1:0] r;
    if (v > PEN_MAX) begin
      r = PEN_W'(PEN_MAX);
    end else if (v < PEN_MIN) begin
      r = PEN_W'(PEN_MIN);
    end else begin
      r = v[PEN_W-1:0];
    end
    return r;
  endfunction

  // round half up to whole pixels and saturate to 16 bits
  function automatic logic [COORD_W-1:0] round_out(input logic signed [PEN_W-1:0] p);
    logic signed [PEN_W:0] s;
    logic signed [PEN_W:0] q;
    logic [COORD_W-1:0]    r;
    s = (PEN_W+1)'(p) + (PEN_W+1)'(1 << (FRACTION_BITS - 1));
    q = s >>> FRACTION_BITS;
    if (q > (PEN_W+1)'(32767)) begin
      r = 16'h7FFF;
    end else if (q < (PEN_W+1)'(-32768)) begin
      r = 16'h8000;
    end else begin
      r = q[COORD_W-1:0];
    end
    return r;
  endfunction

  // decode of the offered item
  assign stat.in_draw    = (symbol == SYM_DRAW);
  assign stat.in_restart = restart;
  assign stat.pend_draw  = is_draw;
  assign stat.out_free   = !out_valid || out_ready;
  assign stat.iter_done  = (iter == ITER_W'(CORDIC_ITERATIONS - 1));

  // start point in pen format
  assign start_x_fix = SAT_W'(start_x) <<< FRACTION_BITS;
  assign start_y_fix = SAT_W'(start_y) <<< FRACTION_BITS;

  // heading after restart and turn
  always_comb begin
    heading_next = restart ? '0 : heading;
    case (symbol)
      SYM_LEFT:  heading_next = heading_next + turn_angle;
      SYM_RIGHT: heading_next = heading_next - turn_angle;
      default:   heading_next = heading_next;
    endcase
  end

  // CORDIC seed: back half-plane negates the vector and turns by half a turn
  assign back_half = heading[ANGLE_W-1] ^ heading[ANGLE_W-2];
  assign angle_rot = {heading[ANGLE_W-1] ^ back_half, heading[ANGLE_W-2:0]};
  assign x_seed    = back_half ? -$signed(X_W'(prod[PROD_W-1:32-GUARD_BITS]))
                               :  $signed(X_W'(prod[PROD_W-1:32-GUARD_BITS]));
  assign z_seed    = {{(Z_W-ANGLE_W-16){angle_rot[ANGLE_W-1]}}, angle_rot, 16'h0000};

  // micro-rotation terms
  assign x_shift   = x >>> iter;
  assign y_shift   = y >>> iter;
  assign atan_step = $signed(Z_W'(ATAN_TAB[ATAN_IDX_W'(iter)]));

  // guard-bit rounding and pen sums
  assign x_guard = x + $signed(X_W'(1 << (GUARD_BITS - 1)));
  assign y_guard = y + $signed(X_W'(1 << (GUARD_BITS - 1)));
  assign x_sum   = ADD_W'(pen_x) + ADD_W'($signed(x_guard[X_W-1:GUARD_BITS]));
  assign y_sum   = ADD_W'(pen_y) + ADD_W'($signed(y_guard[X_W-1:GUARD_BITS]));

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step_length <= STEP_W'(65536);
      turn_angle  <= ANGLE_W'(10923);
      start_x     <= '0;
      start_y     <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_STEP:    step_length <= wr_data[STEP_W-1:0];
        REG_TURN:    turn_angle  <= wr_data[ANGLE_W-1:0];
        REG_START_X: start_x     <= $signed(wr_data[COORD_W-1:0]);
        REG_START_Y: start_y     <= $signed(wr_data[COORD_W-1:0]);
        default:     ;
      endcase
    end
  end

  // pen, heading and item flag
  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x   <= '0;
      pen_y   <= '0;
      heading <= '0;
      is_draw <= 1'b0;
    end else begin
      if (cmd.take) begin
        heading <= heading_next;
        is_draw <= (symbol == SYM_DRAW);
        if (restart) begin
          pen_x <= sat_pen(start_x_fix);
          pen_y <= sat_pen(start_y_fix);
        end
      end
      if (cmd.add) begin
        pen_x <= sat_pen(SAT_W'(x_sum));
        pen_y <= sat_pen(SAT_W'(y_sum));
      end
    end
  end

  // gain multiply and CORDIC iterations
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= PROD_W'(step_length) * PROD_W'(INV_GAIN_Q32);
    end
    if (cmd.load) begin
      x    <= x_seed;
      y    <= '0;
      z    <= z_seed;
      iter <= '0;
    end else if (cmd.iter) begin
      if (!z[Z_W-1]) begin
        x <= x - y_shift;
        y <= y + x_shift;
        z <= z - atan_step;
      end else begin
        x <= x + y_shift;
        y <= y - x_shift;
        z <= z + atan_step;
      end
      iter <= iter + ITER_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_move || cmd.emit_draw) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_move || cmd.emit_draw) begin
      out_x    <= round_out(pen_x);
      out_y    <= round_out(pen_y);
      out_down <= cmd.emit_draw;
      out_last <= cmd.emit_draw || !is_draw;
    end
  end

endmodule

`default_nettype wire

>>> rtl/turtle_vector_generator.sv
// Turtle vector generator: controller and datapath, stream in and out.
// Depends on tvg_pkg, tvg_ctrl and tvg_datapath.
//
// Use:
//   Input items (s_*) carry one command symbol in s_tdata and the restart
//   flag in s_tuser. 'F' draws one step along the heading, '+' and '-'
//   turn, all else is ignored. Restart returns the pen to the start point
//   with heading zero and first emits a pen-up move there.
//   Result items (m_*) carry the rounded, saturated pen target; m_tuser is
//   pen_down and m_tlast marks the final result of an input item. The user
//   must see that registers are written through wr_en / wr_index / wr_data
//   only while idle; the block itself does not enforce it.
// Sequence:
//   A turn or ignored symbol is done in the step that accepts it. An 'F'
//   runs accept, gain multiply, CORDIC load, CORDIC iterations at one per
//   cycle, pen add and result load. A restart first adds a move result.
//   Result loads wait for the output register. One item is worked on at a time.
// Reset and stalls:
//   rst clears the pen, heading and configuration to their defaults and
//   empties the output register. A waiting result sits in the output
//   register; the block keeps working until it needs that register again.
`timescale 1ns / 1ps
`default_nettype none

module turtle_vector_generator
  import tvg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [7:0] symbol
  input  logic                  s_tuser,   // [0] restart
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [31:0]           m_tdata,   // [15:0] point_x, [31:16] point_y
  output logic                  m_tuser,   // [0] pen_down
  output logic                  m_tlast,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data
);

  tvg_cmd_t           cmd;
  tvg_stat_t          stat;
  logic [COORD_W-1:0] point_x;
  logic [COORD_W-1:0] point_y;

  // sequencer
  tvg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // arithmetic and output register
  tvg_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .symbol    (s_tdata),
    .restart   (s_tuser),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_x     (point_x),
    .out_y     (point_y),
    .out_down  (m_tuser),
    .out_last  (m_tlast)
  );

  assign m_tdata = {point_y, point_x};

endmodule

`default_nettype wire

>>> rtl/tvg_checker.sv
// Port-level checks for the turtle vector generator, bound to the top level.
// Depends on tvg_pkg for the symbol codes.
`timescale 1ns / 1ps
`default_nettype none

module tvg_checker
  import tvg_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  s_tvalid,
  input wire logic                  s_tready,
  input wire logic [7:0]            s_tdata,
  input wire logic                  s_tuser,
  input wire logic                  m_tvalid,
  input wire logic                  m_tready,
  input wire logic [31:0]           m_tdata,
  input wire logic                  m_tuser,
  input wire logic                  m_tlast
);

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled result changed");

  // a draw or a restart keeps the input closed while it is worked on
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tdata == SYM_DRAW || s_tuser) |=> !s_tready)
    else $error("input open during draw or restart");

  // a move that is not last is followed by its line before new input
  a_move_then_line: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tuser && !m_tlast |=> m_tvalid || !s_tready)
    else $error("line of a restart draw missing");

endmodule

bind turtle_vector_generator tvg_checker u_tvg_checker (.*);

`default_nettype wire
